// ----- rtl/core/pcx_rle_scanline_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// PCX RLE decoder assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_SCANLINE_DECODER_CORE_ASSERT_SVH
`define PCX_RLE_SCANLINE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PCX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pcx_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// PCX RLE decoder package
// Shared types and constants of the scanline decoder.
// ----------------------------------------------------------------------------
package pcx_rle_pkg;

    localparam logic [7:0] RUN_MARK   = 8'hC0;
    localparam logic [7:0] RUN_MASK   = 8'h3F;
    localparam int unsigned CMD_DEPTH = 2;
    localparam int unsigned CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] REG_BYTES_PER_LINE = 2'd0;
    localparam logic [1:0] REG_PLANE_BYTES    = 2'd1;
    localparam logic [1:0] REG_LINE_COUNT     = 2'd2;

    // one queued job: repeat value count times
    typedef struct packed {
        logic [7:0] value;
        logic [5:0] count;
    } cmd_t;

    typedef struct packed {
        logic [17:0] bytes_per_line;
        logic [15:0] plane_bytes;
        logic [15:0] line_count;
    } cfg_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/core/pcx_rle_front.sv -----
// ----------------------------------------------------------------------------
// PCX RLE front end
// Classifies input bytes into run headers, run values and literals.
// ----------------------------------------------------------------------------
module pcx_rle_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          code_byte,
    input  pcx_rle_pkg::q_stat_t q_stat,
    output logic                push,
    output pcx_rle_pkg::cmd_t   push_cmd
);

    logic       awaiting_reg, awaiting_next;
    logic [5:0] pending_reg, pending_next;
    logic       take;

    assign in_ready = !q_stat.full;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        pending_next   = pending_reg;
        push           = 1'b0;
        push_cmd.value = code_byte;
        push_cmd.count = 6'd1;
        if (take)
        begin
            if (awaiting_reg)
            begin
                awaiting_next  = 1'b0;
                pending_next   = 6'd0;
                push_cmd.count = pending_reg;
                push           = (pending_reg != 6'd0);   // empty run: nothing
            end
            else if ((code_byte & pcx_rle_pkg::RUN_MARK) == pcx_rle_pkg::RUN_MARK)
            begin
                awaiting_next = 1'b1;
                pending_next  = code_byte[5:0] & pcx_rle_pkg::RUN_MASK[5:0];
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            pending_reg  <= 6'd0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// ----- rtl/core/pcx_rle_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// PCX RLE command queue
// Short register queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module pcx_rle_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pcx_rle_pkg::cmd_t    push_cmd,
    input  logic                 pop,
    output pcx_rle_pkg::cmd_t    head,
    output pcx_rle_pkg::q_stat_t stat
);

    localparam int unsigned PW = pcx_rle_pkg::CMD_PTR_W;
    localparam int unsigned CW = pcx_rle_pkg::CMD_CNT_W;
    localparam logic [PW-1:0] LAST_PTR = PW'(pcx_rle_pkg::CMD_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(pcx_rle_pkg::CMD_DEPTH);

    pcx_rle_pkg::cmd_t mem_reg [pcx_rle_pkg::CMD_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign stat.full  = (cnt_reg == DEPTH_C);
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/pcx_rle_back.sv -----
// ----------------------------------------------------------------------------
// PCX RLE back end
// Expands queued jobs into decoded bytes and tracks plane, column and line.
// ----------------------------------------------------------------------------
module pcx_rle_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcx_rle_pkg::cfg_t    cfg,
    input  pcx_rle_pkg::cmd_t    head,
    input  pcx_rle_pkg::q_stat_t q_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           data_byte,
    output logic [1:0]           plane_index,
    output logic [15:0]          column_index,
    output logic [15:0]          line_index,
    output logic                 line_end,
    output logic                 image_end,
    output logic                 run_last
);

    `include "pcx_rle_scanline_decoder_core_assert.svh"

    logic        busy_reg, busy_next;
    logic [5:0]  left_reg, left_next;
    logic [17:0] line_pos_reg, line_pos_next;
    logic [15:0] column_reg, column_next;
    logic [1:0]  plane_reg, plane_next;
    logic [15:0] line_reg, line_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_reg;
    logic [1:0]  plane_out_reg;
    logic [15:0] column_out_reg, line_out_reg;
    logic        lend_reg, iend_reg, last_reg;

    logic [5:0]  sel_left;
    logic        fire, lend, iend, last;

    assign sel_left = busy_reg ? left_reg : head.count;
    assign fire     = !q_stat.empty && (!out_valid_reg || out_ready);
    assign lend     = ({1'b0, line_pos_reg} + 19'd1) >= {1'b0, cfg.bytes_per_line};
    assign iend     = lend && (({1'b0, line_reg} + 17'd1) >= {1'b0, cfg.line_count});
    // a run ends early at the line end; the rest of it is dropped
    assign last     = (sel_left == 6'd1) || lend;
    assign pop      = fire && last;

    always_comb
    begin
        busy_next      = busy_reg;
        left_next      = left_reg;
        line_pos_next  = line_pos_reg;
        column_next    = column_reg;
        plane_next     = plane_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fire)
        begin
            out_valid_next = 1'b1;
            busy_next      = !last;
            left_next      = sel_left - 6'd1;
            if (lend)
            begin
                line_pos_next = '0;
                column_next   = '0;
                plane_next    = '0;
                line_next     = iend ? 16'd0 : line_reg + 16'd1;
            end
            else
            begin
                line_pos_next = line_pos_reg + 18'd1;
                if (({1'b0, column_reg} + 17'd1) >= {1'b0, cfg.plane_bytes})
                begin
                    column_next = '0;
                    if (plane_reg != 2'd3)
                        plane_next = plane_reg + 2'd1;
                end
                else
                begin
                    column_next = column_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            line_pos_reg  <= '0;
            column_reg    <= '0;
            plane_reg     <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            line_pos_reg  <= line_pos_next;
            column_reg    <= column_next;
            plane_reg     <= plane_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg       <= head.value;
            plane_out_reg  <= plane_reg;
            column_out_reg <= column_reg;
            line_out_reg   <= line_reg;
            lend_reg       <= lend;
            iend_reg       <= iend;
            last_reg       <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_reg;
    assign plane_index  = plane_out_reg;
    assign column_index = column_out_reg;
    assign line_index   = line_out_reg;
    assign line_end     = lend_reg;
    assign image_end    = iend_reg;
    assign run_last     = last_reg;

    `PCX_ASSERT_NOW(a_no_empty_job, fire, sel_left != 6'd0, "expanding a zero-length job")
    `PCX_ASSERT_NOW(a_busy_has_job, busy_reg, !q_stat.empty, "run in flight without queued job")
    `PCX_ASSERT_NOW(a_iend_lend, out_valid_reg && iend_reg, lend_reg && last_reg,
        "image end without line end")
    `PCX_ASSERT_NEXT(a_line_restart, fire && lend,
        line_pos_reg == 18'd0 && column_reg == 16'd0 && plane_reg == 2'd0,
        "position not cleared after line end")

endmodule

// ----- rtl/core/pcx_rle_scanline_decoder_core.sv -----
// ----------------------------------------------------------------------------
// PCX RLE scanline decoder core
// Decodes a PCX run-length byte stream into tagged scanline bytes.
//
//   channel  dir  width  accepted when
//   s_*      in   8      s_tvalid && s_tready    (compressed bytes)
//   m_*      out  48+2+1 m_tvalid && m_tready    (decoded bytes)
//   cfg_*    in   2+18   cfg_we                  (register writes)
//
// Flow: a literal byte passes from the classifier straight into the job queue,
//   then through the expander's output register; a run value yields one decoded
//   byte per cycle unless m_tready stalls, up to 63. A run header yields nothing.
// Stalls: the two-entry job queue lets the input keep flowing while the
//   expander waits on m_tready; s_tready drops only when the queue is full.
// Reset: rst_n clears all control state at once; config registers come up at 1.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    // compressed input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] code_byte
    // decoded output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [7:0] data_byte, [9:8] plane_index,
                                     // [25:10] column_index, [41:26] line_index,
                                     // [47:42] zero
    output logic [1:0]  m_tuser,     // [0] line_end, [1] image_end
    output logic        m_tlast,     // run_last
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    pcx_rle_pkg::cfg_t    cfg_reg;
    pcx_rle_pkg::q_stat_t q_stat;
    pcx_rle_pkg::cmd_t    push_cmd, head;
    logic                 push, pop;

    logic [7:0]  data_byte;
    logic [1:0]  plane_index;
    logic [15:0] column_index, line_index;
    logic        line_end, image_end, run_last;

    // register file; the user must write only while the block is idle (unchecked here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_line <= 18'd1;
            cfg_reg.plane_bytes    <= 16'd1;
            cfg_reg.line_count     <= 16'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pcx_rle_pkg::REG_BYTES_PER_LINE: cfg_reg.bytes_per_line <= cfg_data;
                pcx_rle_pkg::REG_PLANE_BYTES:    cfg_reg.plane_bytes    <= cfg_data[15:0];
                pcx_rle_pkg::REG_LINE_COUNT:     cfg_reg.line_count     <= cfg_data[15:0];
                default: ;   // unmapped index: write is dropped
            endcase
        end
    end

    // classifier: headers are held here, values and literals become jobs
    pcx_rle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .code_byte (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    pcx_rle_cmd_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // expander: one decoded byte per transfer, output register inside
    pcx_rle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head         (head),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .data_byte    (data_byte),
        .plane_index  (plane_index),
        .column_index (column_index),
        .line_index   (line_index),
        .line_end     (line_end),
        .image_end    (image_end),
        .run_last     (run_last)
    );

    assign m_tdata = {6'd0, line_index, column_index, plane_index, data_byte};
    assign m_tuser = {image_end, line_end};
    assign m_tlast = run_last;

endmodule
